>>> rtl/bblur_pkg.sv
package bblur_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Register and field widths are fixed by the port
  localparam int DIM_W     = 11;
  localparam int ROW_W     = 11;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CFG_IDX_W = 2;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;

  // Neighbourhood arithmetic: up to nine samples
  localparam int CNT_W     = 4;
  localparam int SUM_W     = CH_W + CNT_W;
  localparam int NUM_W     = SUM_W + 1;
  localparam int DEN_W     = CNT_W + 1;
  localparam int DIV_STEPS = CH_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int MAX_TRIES = 3;
  localparam int TRY_W     = $clog2(MAX_TRIES);

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Index 2 is red, 1 green, 0 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic            func;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } req_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_LOAD,
    ST_SUM,
    ST_DIV,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic load;
    logic abort;
    logic sum;
    logic step;
    logic put;
  } cmd_t;

  typedef struct packed {
    logic pending_zero;
    logic item_flush;
    logic emit;
  } status_t;

endpackage

>>> rtl/bblur_ram.sv
module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bblur_ctrl.sv
module bblur_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_flush,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  bblur_pkg::status_t  status,
  output bblur_pkg::cmd_t     cmd
);
  import bblur_pkg::*;

  state_t            state, state_next;
  logic [TRY_W-1:0]  tries, tries_next;
  logic [STEP_W-1:0] div_count, div_count_next;
  logic              rsp_valid_next;
  logic              out_free;
  logic              last_try;

  assign out_free = !rsp_valid || !rsp_stall;
  assign last_try = (tries == TRY_W'(MAX_TRIES - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req_flush && status.pending_zero) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: state_next = ST_LOAD;
      ST_LOAD: begin
        if (status.emit) begin
          state_next = ST_SUM;
        end else if (status.item_flush && !last_try) begin
          state_next = ST_ISSUE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SUM: state_next = ST_DIV;
      ST_DIV: begin
        if (div_count == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    req_stall      = (state != ST_IDLE);
    tries_next     = tries;
    div_count_next = div_count;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      ST_IDLE: begin
        cmd.accept = req_valid;
        tries_next = '0;
      end
      ST_ISSUE: cmd.issue = 1'b1;
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (!status.emit && status.item_flush) begin
          cmd.abort  = last_try;
          tries_next = tries + TRY_W'(1);
        end
      end
      ST_SUM: begin
        cmd.sum        = 1'b1;
        div_count_next = '0;
      end
      ST_DIV: begin
        cmd.step       = 1'b1;
        div_count_next = div_count + STEP_W'(1);
      end
      ST_PUT: begin
        cmd.put = out_free;
        if (out_free) begin
          rsp_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tries     <= '0;
      div_count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tries     <= tries_next;
      div_count <= div_count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

>>> rtl/bblur_dp.sv
module bblur_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  bblur_pkg::req_t             req_data,
  input  logic                        cfg_wr,
  input  bblur_pkg::cfg_idx_t         cfg_index,
  input  logic [bblur_pkg::DIM_W-1:0] cfg_data,
  input  bblur_pkg::cmd_t             cmd,
  output bblur_pkg::status_t          status,
  output bblur_pkg::rsp_t             rsp_data
);
  import bblur_pkg::*;

  // Control state
  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [DIM_W-1:0] pending;
  logic             item_flush;
  logic             emit;
  rgb_t             win [3][3];

  // Payload
  rgb_t             item_pix;
  logic [COL_W-1:0] col_rd;
  logic             frame_end;
  logic [2:0]       row_mask;
  logic [2:0]       col_mask;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem [NUM_CH];
  logic [CH_W-1:0]  quo [NUM_CH];

  // Combinational
  logic [COL_W-1:0] j;
  logic             pre, post;
  logic [2:0]       row_mask_c, col_mask_c;
  logic [DIM_W-1:0] col_inc;
  logic [ROW_W-1:0] row_inc;
  logic             wrap;
  logic [ROW_W-1:0] row_after;
  rgb_t             load_pix;
  rgb_t             up_rd, mid_rd;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] sums [NUM_CH];
  logic [NUM_W-1:0] num  [NUM_CH];
  logic [DEN_W:0]   trial [NUM_CH];
  logic             ge    [NUM_CH];

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] vmax);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > vmax) begin
      r = vmax;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign status.pending_zero = (pending == '0);
  assign status.item_flush   = item_flush;
  assign status.emit         = emit;

  // Column actually used; a stale column past the row end wraps to zero
  assign j = (DIM_W'(col) >= width_eff) ? '0 : col;

  // Row end owes the last pixel of two rows back; otherwise the one to the left
  assign pre  = (j == '0) && (row >= ROW_W'(2));
  assign post = (j != '0) && (row >= ROW_W'(1));

  // Masks are taken against the window after the shift
  always_comb begin
    if (pre) begin
      row_mask_c = {row <= height_eff, 1'b1, row >= ROW_W'(3)};
      col_mask_c = {1'b0, 1'b1, width_eff >= DIM_W'(2)};
    end else begin
      row_mask_c = {row < height_eff, 1'b1, row >= ROW_W'(2)};
      col_mask_c = {1'b1, 1'b1, j >= COL_W'(2)};
    end
  end

  assign col_inc   = DIM_W'(col_rd) + DIM_W'(1);
  assign wrap      = (col_inc >= width_eff);
  assign row_inc   = row + ROW_W'(1);
  assign row_after = wrap ? row_inc : row;
  assign load_pix  = item_flush ? '0 : item_pix;

  bblur_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (col_rd),
    .wr_data (mid_rd),
    .rd_en   (cmd.issue),
    .rd_addr (j),
    .rd_data (up_rd)
  );

  bblur_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (col_rd),
    .wr_data (load_pix),
    .rd_en   (cmd.issue),
    .rd_addr (j),
    .rd_data (mid_rd)
  );

  always_comb begin
    cnt = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sums[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_mask[r] && col_mask[c]) begin
          cnt = cnt + CNT_W'(1);
          for (int ch = 0; ch < NUM_CH; ch++) begin
            sums[ch] = sums[ch] + SUM_W'(win[r][c][ch]);
          end
        end
      end
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      num[ch] = {sums[ch], 1'b0} + NUM_W'(cnt);
    end
  end

  // Restoring divide, one quotient bit per step; quotient shifts into quo
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      trial[ch] = {rem[ch], quo[ch][CH_W-1]};
      ge[ch]    = (trial[ch] >= {1'b0, den});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= MAX_W_DIM;
      height_eff <= MAX_H_DIM;
      col        <= '0;
      row        <= '0;
      pending    <= '0;
      item_flush <= 1'b0;
      emit       <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            width_eff <= clamp_dim(cfg_data, MAX_W_DIM);
            col       <= '0;
            row       <= '0;
            pending   <= '0;
          end
          CFG_IMAGE_HEIGHT: begin
            height_eff <= clamp_dim(cfg_data, MAX_H_DIM);
            col        <= '0;
            row        <= '0;
            pending    <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.accept) begin
        item_flush <= req_data.func;
        // A pixel after a finished frame starts a new one; drop what is owed
        if (req_data.func == FUNC_PIXEL && (pending != '0 || row >= height_eff)) begin
          col     <= '0;
          row     <= '0;
          pending <= '0;
        end
      end
      if (cmd.issue) begin
        emit <= pre || post;
      end
      if (cmd.load) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= up_rd;
        win[1][2] <= mid_rd;
        win[2][2] <= load_pix;
        col       <= wrap ? '0 : col_inc[COL_W-1:0];
        row       <= row_after;
        if (!item_flush && row_after >= height_eff) begin
          pending <= (height_eff == DIM_W'(1)) ? width_eff : width_eff + DIM_W'(1);
        end
      end
      if (cmd.abort) begin
        col     <= '0;
        row     <= '0;
        pending <= '0;
      end
      if (cmd.put && item_flush) begin
        pending <= pending - DIM_W'(1);
        if (pending == DIM_W'(1)) begin
          col <= '0;
          row <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_pix <= {req_data.in_red, req_data.in_green, req_data.in_blue};
    end
    if (cmd.issue) begin
      col_rd    <= j;
      frame_end <= pre && (row == height_eff + DIM_W'(1));
      row_mask  <= row_mask_c;
      col_mask  <= col_mask_c;
    end
    if (cmd.sum) begin
      den <= {cnt, 1'b0};
      for (int ch = 0; ch < NUM_CH; ch++) begin
        rem[ch] <= num[ch][NUM_W-1:CH_W];
        quo[ch] <= num[ch][CH_W-1:0];
      end
    end
    if (cmd.step) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        rem[ch] <= ge[ch] ? DEN_W'(trial[ch] - {1'b0, den}) : trial[ch][DEN_W-1:0];
        quo[ch] <= {quo[ch][CH_W-2:0], ge[ch]};
      end
    end
    if (cmd.put) begin
      rsp_data.out_red   <= quo[2];
      rsp_data.out_green <= quo[1];
      rsp_data.out_blue  <= quo[0];
      rsp_data.frame_end <= frame_end;
    end
  end

endmodule

>>> rtl/box_blur_3x3_edge_aware.sv
// A request that yields a pixel passes through a line store read, a window shift, a window
// sum and an 8-step divide before it loads the output register.
// A new request stalls until the last is done; a flush with nothing owed never leaves idle;
// a flush that must step over a row start issues and loads once more per extra step.
// Reset: position, pending count and window clear; width and height return to 1024.
// Line store contents are undefined after reset; no clearing pass is run.
module box_blur_3x3_edge_aware (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  bblur_pkg::req_t             req_data,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output bblur_pkg::rsp_t             rsp_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  bblur_pkg::cfg_idx_t         cfg_index,
  input  logic [bblur_pkg::DIM_W-1:0] cfg_data
);
  import bblur_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  bblur_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_flush (req_data.func == FUNC_FLUSH),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bblur_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_data  (rsp_data)
  );

endmodule
